// ===== hw/rtl/aabc_pkg.sv =====
// shared types, constants and helpers for the argb alpha blend converter
package aabc_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumLanes = PixW / ChanW;
  localparam int unsigned LaneSelW = $clog2(NumLanes);
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned AddrW    = RegIdxW + 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * ChanW;

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  typedef enum logic [RegIdxW-1:0] {
    REG_SRC_RED   = 3'd0,
    REG_SRC_GREEN = 3'd1,
    REG_SRC_BLUE  = 3'd2,
    REG_SRC_ALPHA = 3'd3,
    REG_DST_RED   = 3'd4,
    REG_DST_GREEN = 3'd5,
    REG_DST_BLUE  = 3'd6,
    REG_DST_AMASK = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LaneSelW-1:0] src_red_lane;
    logic [LaneSelW-1:0] src_green_lane;
    logic [LaneSelW-1:0] src_blue_lane;
    logic [LaneSelW-1:0] src_alpha_lane;
    logic [LaneSelW-1:0] dst_red_lane;
    logic [LaneSelW-1:0] dst_green_lane;
    logic [LaneSelW-1:0] dst_blue_lane;
    logic [PixW-1:0]     dst_alpha_mask;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    src_red_lane:   2'd2,
    src_green_lane: 2'd1,
    src_blue_lane:  2'd0,
    src_alpha_lane: 2'd3,
    dst_red_lane:   2'd2,
    dst_green_lane: 2'd1,
    dst_blue_lane:  2'd0,
    dst_alpha_mask: 32'hFF00_0000
  };

  function automatic logic [ChanW-1:0] lane_get(input logic [PixW-1:0] px,
                                                input logic [LaneSelW-1:0] lane);
    logic [ChanW-1:0] b;
    b = px[lane*ChanW +: ChanW];
    return b;
  endfunction

  function automatic logic [PixW-1:0] lane_put(input logic [ChanW-1:0] b,
                                               input logic [LaneSelW-1:0] lane);
    logic [PixW-1:0] px;
    px = '0;
    px[lane*ChanW +: ChanW] = b;
    return px;
  endfunction

endpackage

// ===== hw/rtl/aabc_cfg_regs.sv =====
// apb configuration registers for the lane map and alpha mask
module aabc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aabc_pkg::AddrW-1:0]  paddr,
  input  logic [aabc_pkg::DataW-1:0]  pwdata,
  output logic [aabc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output aabc_pkg::cfg_t              cfg_o
);

  aabc_pkg::cfg_t cfg_q, cfg_d;
  aabc_pkg::reg_idx_e idx;
  logic wr_en;

  assign idx    = aabc_pkg::reg_idx_e'(paddr[aabc_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        aabc_pkg::REG_SRC_RED:   cfg_d.src_red_lane   = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_SRC_GREEN: cfg_d.src_green_lane = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_SRC_BLUE:  cfg_d.src_blue_lane  = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_SRC_ALPHA: cfg_d.src_alpha_lane = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_DST_RED:   cfg_d.dst_red_lane   = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_DST_GREEN: cfg_d.dst_green_lane = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_DST_BLUE:  cfg_d.dst_blue_lane  = pwdata[aabc_pkg::LaneSelW-1:0];
        aabc_pkg::REG_DST_AMASK: cfg_d.dst_alpha_mask = pwdata[aabc_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      aabc_pkg::REG_SRC_RED:   prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.src_red_lane;
      aabc_pkg::REG_SRC_GREEN: prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.src_green_lane;
      aabc_pkg::REG_SRC_BLUE:  prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.src_blue_lane;
      aabc_pkg::REG_SRC_ALPHA: prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.src_alpha_lane;
      aabc_pkg::REG_DST_RED:   prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.dst_red_lane;
      aabc_pkg::REG_DST_GREEN: prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.dst_green_lane;
      aabc_pkg::REG_DST_BLUE:  prdata[aabc_pkg::LaneSelW-1:0] = cfg_q.dst_blue_lane;
      aabc_pkg::REG_DST_AMASK: prdata[aabc_pkg::PixW-1:0]     = cfg_q.dst_alpha_mask;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= aabc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/aabc_convert.sv =====
// stage 1: channel reorder, alpha mask and alpha pick
module aabc_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aabc_pkg::cfg_t                  cfg_i,
  input  logic                            in_vld_i,
  input  logic [aabc_pkg::PixW-1:0]       src_pixel_i,
  input  logic [aabc_pkg::PixW-1:0]       dst_pixel_i,
  input  logic                            adv_i,
  output logic                            vld_o,
  output logic [aabc_pkg::PixW-1:0]       conv_o,
  output logic [aabc_pkg::PixW-1:0]       dst_o,
  output logic [aabc_pkg::ChanW-1:0]      alpha_o
);

  logic                        vld_q;
  logic [aabc_pkg::PixW-1:0]   conv_q, conv_d;
  logic [aabc_pkg::PixW-1:0]   dst_q;
  logic [aabc_pkg::ChanW-1:0]  alpha_q, alpha_d;

  always_comb begin
    conv_d = aabc_pkg::lane_put(aabc_pkg::lane_get(src_pixel_i, cfg_i.src_red_lane),
                                cfg_i.dst_red_lane)
           | aabc_pkg::lane_put(aabc_pkg::lane_get(src_pixel_i, cfg_i.src_green_lane),
                                cfg_i.dst_green_lane)
           | aabc_pkg::lane_put(aabc_pkg::lane_get(src_pixel_i, cfg_i.src_blue_lane),
                                cfg_i.dst_blue_lane)
           | cfg_i.dst_alpha_mask;
    alpha_d = aabc_pkg::lane_get(src_pixel_i, cfg_i.src_alpha_lane);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_vld_i) begin
      conv_q  <= conv_d;
      dst_q   <= dst_pixel_i;
      alpha_q <= alpha_d;
    end
  end

  assign vld_o   = vld_q;
  assign conv_o  = conv_q;
  assign dst_o   = dst_q;
  assign alpha_o = alpha_q;

endmodule

// ===== hw/rtl/aabc_blend.sv =====
// stages 2 and 3: per-lane products, then sum and divide by 255
module aabc_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_vld_i,
  input  logic [aabc_pkg::PixW-1:0]       conv_i,
  input  logic [aabc_pkg::PixW-1:0]       dst_i,
  input  logic [aabc_pkg::ChanW-1:0]      alpha_i,
  input  logic                            out_stall_i,
  output logic                            adv_o,
  output logic                            out_vld_o,
  output logic [aabc_pkg::PixW-1:0]       blended_o
);

  localparam int unsigned NL = aabc_pkg::NumLanes;
  localparam int unsigned CW = aabc_pkg::ChanW;
  localparam int unsigned PW = aabc_pkg::ProdW;

  logic              mul_vld_q, out_vld_q;
  logic              adv_mul, adv_out;
  logic [PW-1:0]     ps_q [NL];
  logic [PW-1:0]     pd_q [NL];
  logic [aabc_pkg::PixW-1:0] res_d, res_q;
  logic [CW-1:0]     inv_a;

  assign adv_out = !out_vld_q || !out_stall_i;
  assign adv_mul = !mul_vld_q || adv_out;
  assign inv_a   = aabc_pkg::ChanMax - alpha_i;

  always_ff @(posedge clk_i) begin
    if (adv_mul && in_vld_i) begin
      for (int unsigned c = 0; c < NL; c++) begin
        ps_q[c] <= PW'(conv_i[c*CW +: CW]) * PW'(alpha_i);
        pd_q[c] <= PW'(dst_i[c*CW +: CW]) * PW'(inv_a);
      end
    end
  end

  always_comb begin
    logic [PW-1:0] t;
    logic [PW-1:0] u;
    res_d = '0;
    for (int unsigned c = 0; c < NL; c++) begin
      t = ps_q[c] + pd_q[c] + PW'(1);
      u = t + PW'(t[PW-1:CW]);
      res_d[c*CW +: CW] = u[PW-1:CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && mul_vld_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_mul) begin
        mul_vld_q <= in_vld_i;
      end
      if (adv_out) begin
        out_vld_q <= mul_vld_q;
      end
    end
  end

  assign adv_o         = adv_mul;
  assign out_vld_o     = out_vld_q;
  assign blended_o     = res_q;

endmodule

// ===== hw/rtl/argb_alpha_blend_convert.sv =====
// top level of the argb alpha blend converter
// Source-over alpha blend of one 32-bit source pixel onto one 32-bit destination
// pixel per item, with the source channels moved to the destination layout and
// the alpha mask ORed in before blending. A three-stage pipeline (channel convert,
// lane multipliers, sum and divide by 255) takes one item per clock unless the
// output stalls; each item passes the convert, product and result registers.
// in_stall_o rises only when all three stages hold items and the output is stalled.
// Lane registers sit at byte address 4*i on the apb port; the user must write
// them only while the pipeline is empty, as the block does not enforce it.
module argb_alpha_blend_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aabc_pkg::AddrW-1:0]      paddr,
  input  logic [aabc_pkg::DataW-1:0]      pwdata,
  output logic [aabc_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [aabc_pkg::PixW-1:0]       src_pixel_i,
  input  logic [aabc_pkg::PixW-1:0]       dst_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [aabc_pkg::PixW-1:0]       blended_pixel_o
);

  aabc_pkg::cfg_t             cfg;
  logic                       cv_vld;
  logic                       cv_adv;
  logic                       mul_adv;
  logic [aabc_pkg::PixW-1:0]  cv_conv;
  logic [aabc_pkg::PixW-1:0]  cv_dst;
  logic [aabc_pkg::ChanW-1:0] cv_alpha;

  aabc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign cv_adv     = !cv_vld || mul_adv;
  assign in_stall_o = !cv_adv;

  aabc_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_vld_i    (in_valid_i),
    .src_pixel_i (src_pixel_i),
    .dst_pixel_i (dst_pixel_i),
    .adv_i       (cv_adv),
    .vld_o       (cv_vld),
    .conv_o      (cv_conv),
    .dst_o       (cv_dst),
    .alpha_o     (cv_alpha)
  );

  aabc_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (cv_vld),
    .conv_i      (cv_conv),
    .dst_i       (cv_dst),
    .alpha_i     (cv_alpha),
    .out_stall_i (out_stall_i),
    .adv_o       (mul_adv),
    .out_vld_o   (out_valid_o),
    .blended_o   (blended_pixel_o)
  );

endmodule

// ===== hw/rtl/aabc_checker.sv =====
// port-level checker for the argb alpha blend converter, bound to the top level
module aabc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pready,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [aabc_pkg::PixW-1:0]  blended_pixel_o
);

  // held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(blended_pixel_o))
    else $error("stalled item changed");

  // input backs up only behind a stalled, occupied output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // an accepted item reaches the output while the output is not stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("item did not reach output");

  // no result after a reset edge, register port never waits
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && pready)
    else $error("output valid or port busy in reset");

endmodule

bind argb_alpha_blend_convert aabc_checker u_aabc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .blended_pixel_o (blended_pixel_o)
);

// ===== verif/tb_argb_alpha_blend_convert.sv =====
// self-checking testbench for the argb alpha blend converter: directed table then random phases
`timescale 1ns / 1ps

module tb_argb_alpha_blend_convert;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned NumPhases    = 14;
  localparam int unsigned PhaseItems   = 132;
  localparam int unsigned SettleCycles = 6;

  typedef enum logic {
    ROW_PIXEL,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    aabc_pkg::reg_idx_e    idx;
    logic [31:0]           a;
    logic [31:0]           b;
    logic [31:0]           want;
    logic                  typed;
  } row_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          psel            = 1'b0;
  logic                          penable         = 1'b0;
  logic                          pwrite          = 1'b0;
  logic [aabc_pkg::AddrW-1:0]    paddr           = '0;
  logic [aabc_pkg::DataW-1:0]    pwdata          = '0;
  logic [aabc_pkg::DataW-1:0]    prdata;
  logic                          pready;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [aabc_pkg::PixW-1:0]     src_pixel_i     = '0;
  logic [aabc_pkg::PixW-1:0]     dst_pixel_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic [aabc_pkg::PixW-1:0]     blended_pixel_o;

  aabc_pkg::cfg_t  blend_cfg;
  logic [31:0]     expected_blends [$];
  row_t            dir_rows [$];
  bit              gaps_on   = 1'b1;
  bit              stalls_on = 1'b1;
  int unsigned     n_pixels;
  int unsigned     n_blends;
  int unsigned     n_errors;
  int unsigned     n_mismatch;
  int unsigned     n_settings;
  int unsigned     quiet_cycles;

  argb_alpha_blend_convert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .src_pixel_i    (src_pixel_i),
    .dst_pixel_i    (dst_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blended_pixel_o(blended_pixel_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] byte_at(input logic [31:0] px, input logic [1:0] lane);
    logic [31:0] shifted;
    shifted = px >> (32'(lane) * 8);
    return shifted[7:0];
  endfunction

  function automatic logic [31:0] byte_to(input logic [7:0] b, input logic [1:0] lane);
    return 32'(b) << (32'(lane) * 8);
  endfunction

  function automatic logic [31:0] blend_pixel(input aabc_pkg::cfg_t c, input logic [31:0] sp,
                                              input logic [31:0] dp);
    int unsigned alpha;
    int unsigned s;
    int unsigned d;
    int unsigned t;
    logic [31:0] moved;
    logic [31:0] res;
    alpha = byte_at(sp, c.src_alpha_lane);
    moved = byte_to(byte_at(sp, c.src_red_lane), c.dst_red_lane)
          | byte_to(byte_at(sp, c.src_green_lane), c.dst_green_lane)
          | byte_to(byte_at(sp, c.src_blue_lane), c.dst_blue_lane)
          | c.dst_alpha_mask;
    res = '0;
    for (int lane = 0; lane < 4; lane++) begin
      s = byte_at(moved, 2'(lane));
      d = byte_at(dp, 2'(lane));
      t = s * alpha + d * (255 - alpha) + 1;
      res |= byte_to(8'((t + (t >> 8)) >> 8), 2'(lane));
    end
    return res;
  endfunction

  function automatic row_t pix_known(input logic [31:0] sp, input logic [31:0] dp,
                                     input logic [31:0] want);
    return '{kind: ROW_PIXEL, idx: aabc_pkg::REG_SRC_RED, a: sp, b: dp, want: want,
             typed: 1'b1};
  endfunction

  function automatic row_t pix_pred(input logic [31:0] sp, input logic [31:0] dp);
    return '{kind: ROW_PIXEL, idx: aabc_pkg::REG_SRC_RED, a: sp, b: dp, want: '0,
             typed: 1'b0};
  endfunction

  function automatic row_t reg_row(input aabc_pkg::reg_idx_e idx, input logic [31:0] val);
    return '{kind: ROW_REG, idx: idx, a: val, b: '0, want: '0, typed: 1'b0};
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_pixel(input logic [31:0] sp, input logic [31:0] dp,
                            input logic [31:0] want);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    src_pixel_i = sp;
    dst_pixel_i = dp;
    do @(posedge clk_i); while (in_stall_o);
    expected_blends.push_back(want);
    n_pixels++;
    @(negedge clk_i);
  endtask

  task automatic settle_pipe();
    in_valid_i = 1'b0;
    while (expected_blends.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input aabc_pkg::reg_idx_e idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      aabc_pkg::REG_SRC_RED:   blend_cfg.src_red_lane   = val[1:0];
      aabc_pkg::REG_SRC_GREEN: blend_cfg.src_green_lane = val[1:0];
      aabc_pkg::REG_SRC_BLUE:  blend_cfg.src_blue_lane  = val[1:0];
      aabc_pkg::REG_SRC_ALPHA: blend_cfg.src_alpha_lane = val[1:0];
      aabc_pkg::REG_DST_RED:   blend_cfg.dst_red_lane   = val[1:0];
      aabc_pkg::REG_DST_GREEN: blend_cfg.dst_green_lane = val[1:0];
      aabc_pkg::REG_DST_BLUE:  blend_cfg.dst_blue_lane  = val[1:0];
      aabc_pkg::REG_DST_AMASK: blend_cfg.dst_alpha_mask = val;
      default: ;
    endcase
  endtask

  // upper bits of the lane values are junk that the block must drop
  task automatic apply_cfg(input aabc_pkg::cfg_t c);
    settle_pipe();
    write_reg(aabc_pkg::REG_SRC_RED,   ($urandom & 32'hFFFF_FFFC) | 32'(c.src_red_lane));
    write_reg(aabc_pkg::REG_SRC_GREEN, ($urandom & 32'hFFFF_FFFC) | 32'(c.src_green_lane));
    write_reg(aabc_pkg::REG_SRC_BLUE,  ($urandom & 32'hFFFF_FFFC) | 32'(c.src_blue_lane));
    write_reg(aabc_pkg::REG_SRC_ALPHA, ($urandom & 32'hFFFF_FFFC) | 32'(c.src_alpha_lane));
    write_reg(aabc_pkg::REG_DST_RED,   ($urandom & 32'hFFFF_FFFC) | 32'(c.dst_red_lane));
    write_reg(aabc_pkg::REG_DST_GREEN, ($urandom & 32'hFFFF_FFFC) | 32'(c.dst_green_lane));
    write_reg(aabc_pkg::REG_DST_BLUE,  ($urandom & 32'hFFFF_FFFC) | 32'(c.dst_blue_lane));
    write_reg(aabc_pkg::REG_DST_AMASK, c.dst_alpha_mask);
    n_settings++;
  endtask

  always begin
    @(negedge clk_i);
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    logic [31:0] want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blends.size() == 0) begin
        n_errors++;
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("unexpected item: blended_pixel %08h", blended_pixel_o);
        end
      end else begin
        want = expected_blends.pop_front();
        n_blends++;
        if (blended_pixel_o !== want) begin
          n_errors++;
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch on item %0d: blended_pixel expected %08h got %08h",
                     n_blends, want, blended_pixel_o);
          end
        end
      end
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", QuietLimit);
      $display("tb_argb_alpha_blend_convert: done, errors");
      $finish;
    end
  end

  initial begin
    aabc_pkg::cfg_t c;
    logic [31:0]    sp;
    logic [31:0]    dp;
    logic [31:0]    masks [5];
    row_t           r;

    blend_cfg = aabc_pkg::CfgReset;

    // reset layout: alpha 0xff passes the source, alpha 0 keeps the destination
    dir_rows.push_back(pix_known(32'hFF12_3456, 32'h89AB_CDEF, 32'hFF12_3456));
    dir_rows.push_back(pix_known(32'h00FF_FFFF, 32'h1234_5678, 32'h1234_5678));
    dir_rows.push_back(pix_known(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
    dir_rows.push_back(pix_known(32'hFF00_0000, 32'hFFFF_FFFF, 32'hFF00_0000));
    dir_rows.push_back(pix_known(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    dir_rows.push_back(pix_known(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows.push_back(pix_pred(32'h80FF_00FF, 32'h00FF_00FF));
    dir_rows.push_back(pix_pred(32'h7F12_3456, 32'hFEDC_BA98));
    dir_rows.push_back(pix_pred(32'h01FF_FFFF, 32'h0000_0000));
    dir_rows.push_back(pix_pred(32'hFE00_0000, 32'hFFFF_FFFF));
    // no mask: the alpha lane is uncovered and blends toward zero
    dir_rows.push_back(reg_row(aabc_pkg::REG_DST_AMASK, 32'h0000_0000));
    dir_rows.push_back(pix_known(32'hFF11_2233, 32'hAABB_CCDD, 32'h0011_2233));
    // green and blue share lane 0, lane 1 left uncovered
    dir_rows.push_back(reg_row(aabc_pkg::REG_DST_GREEN, 32'hFFFF_FFFC));
    dir_rows.push_back(pix_known(32'hFF11_2244, 32'h5566_7788, 32'h0011_0066));
    // mask bits laid over an empty lane and over channel bytes
    dir_rows.push_back(reg_row(aabc_pkg::REG_DST_AMASK, 32'h00F0_FF0F));
    dir_rows.push_back(pix_pred(32'h8011_2244, 32'h0102_0304));
    dir_rows.push_back(reg_row(aabc_pkg::REG_SRC_ALPHA, 32'h0000_0000));
    dir_rows.push_back(pix_pred(32'h1234_56FF, 32'h0000_0000));
    dir_rows.push_back(reg_row(aabc_pkg::REG_SRC_RED, 32'h0000_0007));
    dir_rows.push_back(reg_row(aabc_pkg::REG_SRC_GREEN, 32'hFFFF_FFFE));
    dir_rows.push_back(reg_row(aabc_pkg::REG_SRC_BLUE, 32'h0000_0001));
    dir_rows.push_back(reg_row(aabc_pkg::REG_DST_RED, 32'h0000_0003));
    dir_rows.push_back(reg_row(aabc_pkg::REG_DST_BLUE, 32'h8000_0005));
    dir_rows.push_back(pix_pred(32'hA5C3_5A3C, 32'h0F0F_F0F0));
    dir_rows.push_back(pix_pred(32'h0000_00FF, 32'hFFFF_FFFF));

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    n_settings = 1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_REG) begin
        settle_pipe();
        write_reg(r.idx, r.a);
        n_settings++;
      end else begin
        send_pixel(r.a, r.b, r.typed ? r.want : blend_pixel(blend_cfg, r.a, r.b));
      end
    end

    masks[0] = 32'h0000_0000;
    masks[1] = 32'hFF00_0000;
    masks[2] = 32'hFFFF_FFFF;
    masks[3] = 32'h0000_00FF;
    masks[4] = 32'h00FF_0000;

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 32'hFFFF_FFFF};
      end else if (p == 2) begin
        c = aabc_pkg::CfgReset;
      end else begin
        c.src_red_lane   = 2'($urandom);
        c.src_green_lane = 2'($urandom);
        c.src_blue_lane  = 2'($urandom);
        c.src_alpha_lane = 2'($urandom);
        c.dst_red_lane   = 2'($urandom);
        c.dst_green_lane = 2'($urandom);
        c.dst_blue_lane  = 2'($urandom);
        c.dst_alpha_mask = ($urandom_range(0, 2) == 0) ? $urandom
                                                       : masks[$urandom_range(0, 4)];
      end
      if (p >= NumPhases - 2) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      apply_cfg(c);
      for (int k = 0; k < PhaseItems; k++) begin
        sp = $urandom;
        dp = $urandom;
        case ($urandom_range(0, 7))
          0: sp[blend_cfg.src_alpha_lane*8 +: 8] = 8'h00;
          1: sp[blend_cfg.src_alpha_lane*8 +: 8] = 8'hFF;
          2: dp = 32'h0000_0000;
          3: dp = 32'hFFFF_FFFF;
          default: ;
        endcase
        send_pixel(sp, dp, blend_pixel(blend_cfg, sp, dp));
      end
    end

    in_valid_i = 1'b0;
    while (expected_blends.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    n_errors += expected_blends.size();

    $display("sent %0d pixels under %0d register settings, %0d blended items checked",
             n_pixels, n_settings, n_blends);
    $display("%0d mismatches, %0d still outstanding", n_mismatch, expected_blends.size());
    if (n_errors == 0) begin
      $display("tb_argb_alpha_blend_convert: done, clean");
    end else begin
      $display("tb_argb_alpha_blend_convert: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/aabc_pkg.sv
hw/rtl/aabc_cfg_regs.sv
hw/rtl/aabc_convert.sv
hw/rtl/aabc_blend.sv
hw/rtl/argb_alpha_blend_convert.sv
hw/rtl/aabc_checker.sv
verif/tb_argb_alpha_blend_convert.sv
